/* src/gpio_rb_pkg.sv */
`timescale 1ns / 1ps

package gpio_rb_pkg;

  // Pin count and the fixed widths of the bus word, the pin vector ports and the group and index fields
  localparam int unsigned PinCount    = 58;
  localparam int unsigned DataW       = 32;
  localparam int unsigned VecW        = 58;
  localparam int unsigned GroupW      = 3;
  localparam int unsigned IdxW        = 3;

  // Field packing inside one bus word
  localparam int unsigned FselBits    = 3;
  localparam int unsigned FselPerWord = 10;
  localparam int unsigned PullBits    = 2;
  localparam int unsigned PullPerWord = 16;

  // Word counts per register group
  localparam int unsigned FsWords   = (PinCount + FselPerWord - 1) / FselPerWord;
  localparam int unsigned BitWords  = (PinCount + DataW - 1) / DataW;
  localparam int unsigned PullWords = (PinCount + PullPerWord - 1) / PullPerWord;

  typedef enum logic {
    OpRead  = 1'b0,
    OpWrite = 1'b1
  } op_e;

  typedef enum logic [GroupW-1:0] {
    GrpFsel  = 3'd0,
    GrpSet   = 3'd1,
    GrpClear = 3'd2,
    GrpLevel = 3'd3,
    GrpPull  = 3'd4
  } reg_group_e;

  localparam logic [FselBits-1:0] FselOutput = 3'b001;
  localparam logic [PullBits-1:0] PullUp     = 2'd1;
  localparam logic [PullBits-1:0] PullDown   = 2'd2;

endpackage

/* src/gpio_register_bank_top.sv */
`timescale 1ns / 1ps

// Channel | direction | handshake               | word
// in      | sink      | in_valid_i / in_stall_o   | op, group, index, write data, pad levels
// out     | source    | out_valid_o / out_stall_i | read data, bad flag, four pin vectors
//
// Each access is held in the input register, then is applied to the pin
// state flops and lands in the result register; one access per cycle is
// sustained while out_stall_i is low. The pin state flops load in the same cycle as the result register.
// Reset clears all function selects, the output latch and the pull codes.
// A stalled result holds the result register; one further access waits in the
// input register, after which in_stall_o rises.
module gpio_register_bank_top (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [2:0]  reg_group_i,
  input  logic [2:0]  word_index_i,
  input  logic [31:0] write_data_i,
  input  logic [57:0] pad_levels_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_data_o,
  output logic        bad_access_o,
  output logic [57:0] pin_drive_o,
  output logic [57:0] pin_output_enable_o,
  output logic [57:0] pull_up_enable_o,
  output logic [57:0] pull_down_enable_o
);

  localparam int unsigned NPins = gpio_rb_pkg::PinCount;
  localparam int unsigned DW    = gpio_rb_pkg::DataW;
  localparam int unsigned VW    = gpio_rb_pkg::VecW;
  localparam int unsigned IW    = gpio_rb_pkg::IdxW;
  localparam int unsigned FB    = gpio_rb_pkg::FselBits;
  localparam int unsigned PB    = gpio_rb_pkg::PullBits;

  // Input register
  logic                              s1_valid_q, s1_valid_d;
  gpio_rb_pkg::op_e                  s1_op_q;
  logic [gpio_rb_pkg::GroupW-1:0]    s1_group_q;
  logic [IW-1:0]                     s1_idx_q;
  logic [DW-1:0]                     s1_data_q;
  logic [VW-1:0]                     s1_pads_q;

  // Pin state
  logic [FB-1:0]    fsel_q [NPins];
  logic [FB-1:0]    fsel_d [NPins];
  logic [PB-1:0]    pull_q [NPins];
  logic [PB-1:0]    pull_d [NPins];
  logic [NPins-1:0] latch_q, latch_d;

  // Result register
  logic          res_valid_q, res_valid_d;
  logic [DW-1:0] res_rd_q, res_rd_d;
  logic          res_bad_q, res_bad_d;
  logic [VW-1:0] res_drive_q, res_drive_d;
  logic [VW-1:0] res_oe_q, res_oe_d;
  logic [VW-1:0] res_pu_q, res_pu_d;
  logic [VW-1:0] res_pd_q, res_pd_d;

  logic             accept;
  logic             advance;
  logic             wr;
  logic [NPins-1:0] oe_now;
  logic [NPins-1:0] pads;
  logic [NPins-1:0] level;
  logic [DW-1:0]    rd;

  // Handshake: the input register moves on when the result register frees up
  assign advance     = s1_valid_q && (!res_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && res_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign s1_valid_d  = accept || (s1_valid_q && !advance);
  assign res_valid_d = advance || (res_valid_q && out_stall_i);
  assign wr          = (s1_op_q == gpio_rb_pkg::OpWrite);

  // Decode the access, build the read word and the next pin state
  always_comb begin
    res_bad_d = 1'b0;
    rd        = '0;
    fsel_d    = fsel_q;
    pull_d    = pull_q;
    latch_d   = latch_q;

    for (int p = 0; p < NPins; p++) begin
      oe_now[p] = (fsel_q[p] == gpio_rb_pkg::FselOutput);
      if (p < VW) begin
        pads[p] = s1_pads_q[p];
      end else begin
        pads[p] = 1'b0;
      end
    end
    level = (latch_q & oe_now) | (pads & ~oe_now);

    unique case (s1_group_q)
      gpio_rb_pkg::GrpFsel: begin
        if (s1_idx_q >= IW'(gpio_rb_pkg::FsWords)) begin
          res_bad_d = 1'b1;
        end else begin
          for (int p = 0; p < NPins; p++) begin
            if (s1_idx_q == IW'(p / gpio_rb_pkg::FselPerWord)) begin
              if (wr) begin
                fsel_d[p] = s1_data_q[FB*(p % gpio_rb_pkg::FselPerWord) +: FB];
              end else begin
                rd[FB*(p % gpio_rb_pkg::FselPerWord) +: FB] = fsel_q[p];
              end
            end
          end
        end
      end
      gpio_rb_pkg::GrpSet, gpio_rb_pkg::GrpClear: begin
        if (s1_idx_q >= IW'(gpio_rb_pkg::BitWords)) begin
          res_bad_d = 1'b1;
        end else if (wr) begin
          for (int p = 0; p < NPins; p++) begin
            if (s1_idx_q == IW'(p / DW) && s1_data_q[p % DW]) begin
              latch_d[p] = (s1_group_q == gpio_rb_pkg::GrpSet);
            end
          end
        end
      end
      gpio_rb_pkg::GrpLevel: begin
        if (s1_idx_q >= IW'(gpio_rb_pkg::BitWords)) begin
          res_bad_d = 1'b1;
        end else if (!wr) begin
          for (int p = 0; p < NPins; p++) begin
            if (s1_idx_q == IW'(p / DW)) begin
              rd[p % DW] = level[p];
            end
          end
        end
      end
      gpio_rb_pkg::GrpPull: begin
        if (s1_idx_q >= IW'(gpio_rb_pkg::PullWords)) begin
          res_bad_d = 1'b1;
        end else begin
          for (int p = 0; p < NPins; p++) begin
            if (s1_idx_q == IW'(p / gpio_rb_pkg::PullPerWord)) begin
              if (wr) begin
                pull_d[p] = s1_data_q[PB*(p % gpio_rb_pkg::PullPerWord) +: PB];
              end else begin
                rd[PB*(p % gpio_rb_pkg::PullPerWord) +: PB] = pull_q[p];
              end
            end
          end
        end
      end
      default: begin
        res_bad_d = 1'b1;
      end
    endcase

    // Drop read data on writes and bad accesses
    res_rd_d = (res_bad_d || wr) ? '0 : rd;

    // Pin vectors after the access, cut to the port width
    for (int p = 0; p < VW; p++) begin
      if (p < NPins) begin
        res_drive_d[p] = latch_d[p];
        res_oe_d[p]    = (fsel_d[p] == gpio_rb_pkg::FselOutput);
        res_pu_d[p]    = (pull_d[p] == gpio_rb_pkg::PullUp);
        res_pd_d[p]    = (pull_d[p] == gpio_rb_pkg::PullDown);
      end else begin
        res_drive_d[p] = 1'b0;
        res_oe_d[p]    = 1'b0;
        res_pu_d[p]    = 1'b0;
        res_pd_d[p]    = 1'b0;
      end
    end
  end

  // Hold control and pin state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      latch_q     <= '0;
      for (int p = 0; p < NPins; p++) begin
        fsel_q[p] <= '0;
        pull_q[p] <= '0;
      end
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
      if (advance) begin
        latch_q <= latch_d;
        fsel_q  <= fsel_d;
        pull_q  <= pull_d;
      end
    end
  end

  // Capture the incoming word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q    <= gpio_rb_pkg::op_e'(op_i);
      s1_group_q <= reg_group_i;
      s1_idx_q   <= word_index_i;
      s1_data_q  <= write_data_i;
      s1_pads_q  <= pad_levels_i;
    end
  end

  // Load the result word
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_rd_q    <= res_rd_d;
      res_bad_q   <= res_bad_d;
      res_drive_q <= res_drive_d;
      res_oe_q    <= res_oe_d;
      res_pu_q    <= res_pu_d;
      res_pd_q    <= res_pd_d;
    end
  end

  assign out_valid_o         = res_valid_q;
  assign read_data_o         = res_rd_q;
  assign bad_access_o        = res_bad_q;
  assign pin_drive_o         = res_drive_q;
  assign pin_output_enable_o = res_oe_q;
  assign pull_up_enable_o    = res_pu_q;
  assign pull_down_enable_o  = res_pd_q;

endmodule

/* src/gpio_rb_checker.sv */
`timescale 1ns / 1ps

module gpio_rb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] read_data_o,
  input logic        bad_access_o,
  input logic [57:0] pull_up_enable_o,
  input logic [57:0] pull_down_enable_o
);

  // A bad access never returns data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_access_o |-> read_data_o == '0)
    else $error("bad access returned non-zero read data");

  // A pin never has both pulls enabled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pull_up_enable_o & pull_down_enable_o) == '0)
    else $error("pull-up and pull-down both enabled");

  // Input back-pressure only when the result side is full and stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while result side can move");

  // A fresh result only follows a word accepted through the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result appeared without an accepted word");

endmodule

bind gpio_register_bank_top gpio_rb_checker u_gpio_rb_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .read_data_o        (read_data_o),
  .bad_access_o       (bad_access_o),
  .pull_up_enable_o   (pull_up_enable_o),
  .pull_down_enable_o (pull_down_enable_o)
);
